FILE: hw/rtl/rgb_to_gray_converter_assert.svh
// assertion macros for the rgb to gray converter checker
`ifndef RGB_TO_GRAY_CONVERTER_ASSERT_SVH
`define RGB_TO_GRAY_CONVERTER_ASSERT_SVH

// clocked assertion, muted while reset is asserted
`define R2G_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define R2G_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/r2g_pkg.sv
// shared types and constants of the rgb to gray converter
package r2g_pkg;

    // conversion modes
    typedef enum logic [1:0] {
        MODE_LUMA  = 2'd0,
        MODE_AVG   = 2'd1,
        MODE_LIGHT = 2'd2,
        MODE_CHAN  = 2'd3
    } t_mode;

    // channel select codes
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;

    // register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_R = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_G = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_SEL = 3'd4;

    // widths
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned WGT_W  = 16;
    localparam int unsigned PROD_W = PIX_W + WGT_W;
    localparam int unsigned ACC_W  = PROD_W + 2;
    localparam int unsigned SUM_W  = PIX_W + 2;
    localparam int unsigned FRAC_BITS = 14;

    // divide by three as multiply by 683 and shift by 11, exact for sums up to 765
    localparam int unsigned AVG_RECIP_W = 10;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = 10'd683;
    localparam int unsigned AVG_SHIFT = 11;
    localparam int unsigned AVG_PROD_W = SUM_W + AVG_RECIP_W;

    // reset weights, q2.14
    localparam logic [WGT_W-1:0] WEIGHT_R_RST = 16'd3482;
    localparam logic [WGT_W-1:0] WEIGHT_G_RST = 16'd11721;
    localparam logic [WGT_W-1:0] WEIGHT_B_RST = 16'd1181;

endpackage

FILE: hw/rtl/rgb_to_gray_converter.sv
// rgb to gray converter: three stage pipeline with a configuration write channel
//
//  channel   dir   payload                             transfer when
//  s (in)    in    tdata = red, green, blue; tlast     i_s_tvalid && o_s_tready
//  m (out)   out   tdata = gray; tlast                 o_m_tvalid && i_m_tready
//  cfg       in    index 3 bits, data 16 bits          i_cfg_valid && o_cfg_ready
//
//  one pixel per clock while the output accepts; an input transfer passes through the
//  three register stages (products, sums, selection) in order on its way to the output
//  the three 8x16 weight multipliers sit beside the sum, max and min in the first stage
//  reset is synchronous, active low, and clears the stage valid bits and the
//  configuration registers to their defaults
//  a stall on the output holds every full stage whose successor is full; empty stages keep
//  filling, so the input stays ready until all three stages are occupied
module rgb_to_gray_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        i_s_tlast,   // last_in
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] gray
    output logic        o_m_tlast,   // last_out
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned PW = r2g_pkg::PIX_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    r2g_pkg::t_mode             r_mode;
    logic [r2g_pkg::WGT_W-1:0]  r_weight_r;
    logic [r2g_pkg::WGT_W-1:0]  r_weight_g;
    logic [r2g_pkg::WGT_W-1:0]  r_weight_b;
    logic [1:0]                 r_chan_sel;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= r2g_pkg::MODE_LUMA;
            r_weight_r <= r2g_pkg::WEIGHT_R_RST;
            r_weight_g <= r2g_pkg::WEIGHT_G_RST;
            r_weight_b <= r2g_pkg::WEIGHT_B_RST;
            r_chan_sel <= r2g_pkg::CHAN_RED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                r2g_pkg::CFG_MODE:     r_mode     <= r2g_pkg::t_mode'(i_cfg_data[1:0]);
                r2g_pkg::CFG_WEIGHT_R: r_weight_r <= i_cfg_data;
                r2g_pkg::CFG_WEIGHT_G: r_weight_g <= i_cfg_data;
                r2g_pkg::CFG_WEIGHT_B: r_weight_b <= i_cfg_data;
                r2g_pkg::CFG_CHAN_SEL: r_chan_sel <= i_cfg_data[1:0];
                default: ;  // indexes past the register list are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage advance: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || i_m_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: weight products, component sum, max and min
    // ---------------------------------------------------------------
    logic [PW-1:0] in_r, in_g, in_b;
    assign in_r = i_s_tdata[0*PW +: PW];
    assign in_g = i_s_tdata[1*PW +: PW];
    assign in_b = i_s_tdata[2*PW +: PW];

    logic [r2g_pkg::PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic [r2g_pkg::PROD_W-1:0] n_prod_r, n_prod_g, n_prod_b;
    logic [r2g_pkg::SUM_W-1:0]  r_sum3, n_sum3;
    logic [PW-1:0]              r_hi, r_lo, n_hi, n_lo;
    logic [PW-1:0]              r_r1, r_g1, r_b1;
    logic                       r_last1;

    always_comb begin
        n_prod_r = r2g_pkg::PROD_W'(in_r) * r2g_pkg::PROD_W'(r_weight_r);
        n_prod_g = r2g_pkg::PROD_W'(in_g) * r2g_pkg::PROD_W'(r_weight_g);
        n_prod_b = r2g_pkg::PROD_W'(in_b) * r2g_pkg::PROD_W'(r_weight_b);
        n_sum3   = r2g_pkg::SUM_W'(in_r) + r2g_pkg::SUM_W'(in_g) + r2g_pkg::SUM_W'(in_b);
        n_hi = in_r;
        n_lo = in_r;
        if (in_g > n_hi) n_hi = in_g;
        if (in_b > n_hi) n_hi = in_b;
        if (in_g < n_lo) n_lo = in_g;
        if (in_b < n_lo) n_lo = in_b;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_prod_r <= n_prod_r;
            r_prod_g <= n_prod_g;
            r_prod_b <= n_prod_b;
            r_sum3   <= n_sum3;
            r_hi     <= n_hi;
            r_lo     <= n_lo;
            r_r1     <= in_r;
            r_g1     <= in_g;
            r_b1     <= in_b;
            r_last1  <= i_s_tlast;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: weighted sum, divide-by-three product, lightness, channel pick
    // ---------------------------------------------------------------
    logic [r2g_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [r2g_pkg::AVG_PROD_W-1:0] r_avg_prod, n_avg_prod;
    logic [PW:0]                    light_sum;
    logic [PW-1:0]                  r_light, r_chan, n_chan;
    logic                           r_last2;

    always_comb begin
        n_acc = r2g_pkg::ACC_W'(r_prod_r) + r2g_pkg::ACC_W'(r_prod_g)
              + r2g_pkg::ACC_W'(r_prod_b);
        n_avg_prod = r2g_pkg::AVG_PROD_W'(r_sum3)
                   * r2g_pkg::AVG_PROD_W'(r2g_pkg::AVG_RECIP);
        light_sum = {1'b0, r_hi} + {1'b0, r_lo};
        case (r_chan_sel)
            r2g_pkg::CHAN_RED:   n_chan = r_r1;
            r2g_pkg::CHAN_GREEN: n_chan = r_g1;
            r2g_pkg::CHAN_BLUE:  n_chan = r_b1;
            default:             n_chan = '0;  // unused select reads as black
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_acc      <= n_acc;
            r_avg_prod <= n_avg_prod;
            r_light    <= light_sum[PW:1];
            r_chan     <= n_chan;
            r_last2    <= r_last1;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: shift and saturate, mode select, output register
    // ---------------------------------------------------------------
    logic [r2g_pkg::ACC_W-r2g_pkg::FRAC_BITS-1:0] luma_int;
    logic [PW-1:0] luma_sat, n_gray, r_gray;
    logic          r_last3;

    always_comb begin
        luma_int = r_acc[r2g_pkg::ACC_W-1:r2g_pkg::FRAC_BITS];
        // anything above the low byte saturates to full white
        luma_sat = (|luma_int[$bits(luma_int)-1:PW]) ? {PW{1'b1}} : luma_int[PW-1:0];
        unique case (r_mode)
            r2g_pkg::MODE_LUMA:  n_gray = luma_sat;
            r2g_pkg::MODE_AVG:   n_gray = r_avg_prod[r2g_pkg::AVG_SHIFT +: PW];
            r2g_pkg::MODE_LIGHT: n_gray = r_light;
            r2g_pkg::MODE_CHAN:  n_gray = r_chan;
            default:             n_gray = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_gray  <= n_gray;
            r_last3 <= r_last2;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_gray;
    assign o_m_tlast  = r_last3;

endmodule

FILE: hw/rtl/r2g_checker.sv
// port level checker for the rgb to gray converter, bound to the top level
`include "rgb_to_gray_converter_assert.svh"

module r2g_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [23:0] i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // output offered but held off
    logic       m_stall;
    logic [8:0] m_pay;
    assign m_stall = o_m_tvalid && !i_m_tready;
    assign m_pay   = {o_m_tlast, o_m_tdata};

    // a stalled output transfer stays offered
    `R2G_ASSERT(a_out_valid_hold, i_clk, i_rst_n, m_stall |=> o_m_tvalid, "valid dropped")

    // a stalled output keeps its payload
    `R2G_ASSERT(a_out_data_hold, i_clk, i_rst_n, m_stall |=> $stable(m_pay), "payload changed")

    // the input only backs up when the output is full and stalled
    `R2G_ASSERT_ALWAYS(a_ready_only_on_stall, i_clk, !o_s_tready |-> m_stall, "ready low")

    // reset empties the pipeline
    `R2G_ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !o_m_tvalid, "valid after reset")

endmodule

bind rgb_to_gray_converter r2g_checker u_r2g_checker (.*);
